>>> design/kd_pkg.sv
// Shared types and constants of the key debouncer with long press and auto repeat.
package kd_pkg;

  localparam int KEYS_MAX   = 3;
  localparam int FT_W       = 7;
  localparam int FC_W       = 8;
  localparam int CNT_W      = 16;
  localparam int CODE_W     = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_ADDR_W-1:0] reg_idx_t;
  typedef logic [CODE_W-1:0]     code_t;

  // Register indexes
  localparam reg_idx_t REG_FILTER_TIME  = 3'd0;
  localparam reg_idx_t REG_LONG_UP      = 3'd1;
  localparam reg_idx_t REG_LONG_OK      = 3'd2;
  localparam reg_idx_t REG_LONG_DOWN    = 3'd3;
  localparam reg_idx_t REG_REPEAT_UP    = 3'd4;
  localparam reg_idx_t REG_REPEAT_OK    = 3'd5;
  localparam reg_idx_t REG_REPEAT_DOWN  = 3'd6;

  localparam reg_idx_t LONG_IDX   [KEYS_MAX] = '{REG_LONG_UP, REG_LONG_OK, REG_LONG_DOWN};
  localparam reg_idx_t REPEAT_IDX [KEYS_MAX] = '{REG_REPEAT_UP, REG_REPEAT_OK, REG_REPEAT_DOWN};

  // Reset values
  localparam logic [FT_W-1:0]  FILTER_TIME_RST  = 7'd5;
  localparam logic [FC_W-1:0]  FILTER_COUNT_RST = {2'b00, FILTER_TIME_RST[FT_W-1:1]};
  localparam logic [CNT_W-1:0] LONG_TIME_RST    = 16'd100;
  localparam logic [CNT_W-1:0] REPEAT_SPEED_RST = 16'd10;

  // Event code offsets within one key's group of three
  localparam code_t CODE_PRESS   = 4'd1;
  localparam code_t CODE_RELEASE = 4'd2;
  localparam code_t CODE_LONG    = 4'd3;

  // Events that one lane raises on one tick: a press or release first,
  // then a long or repeat event
  typedef struct packed {
    logic first_vld;
    logic first_rel;
    logic second_vld;
    logic second_long;
  } lane_ev_t;

endpackage

>>> design/key_debounce_long_repeat.sv
// Top level of the key debouncer with long press and auto repeat.
// Each input word is one scan tick carrying the raw active-low levels of the keys
// (up, ok, down). Every key has its own lane that debounces it with a hysteresis
// counter and raises press, release, long and repeat events; the merge stage sends
// them out one word per cycle while out_tready allows, in key order, with tlast on
// the final event of the tick. A tick causes up to two events per key; the next tick
// is taken only once every event of the previous one has moved into the output
// register, so a stall with events still pending holds the input closed. Writing
// a key's long time or repeat period clears that key's long and repeat counters.
module key_debounce_long_repeat #(
  parameter int NUM_KEYS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // up_level, ok_level, down_level
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // event_code[3:0]
  output logic                              out_tlast,  // last_event
  input  logic                              cfg_we,
  input  kd_pkg::reg_idx_t                  cfg_addr,
  input  logic [kd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import kd_pkg::*;

  logic [FT_W-1:0]             filter_time_r;
  logic [CNT_W-1:0]            long_time_r    [KEYS_MAX];
  logic [CNT_W-1:0]            repeat_speed_r [KEYS_MAX];
  logic [NUM_KEYS-1:0]         key_clr;
  lane_ev_t [NUM_KEYS-1:0]     lane_ev;
  logic                        in_accept;
  code_t                       out_code;

  assign in_accept = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_time_r <= FILTER_TIME_RST;
      for (int k = 0; k < KEYS_MAX; k++) begin
        long_time_r[k]    <= LONG_TIME_RST;
        repeat_speed_r[k] <= REPEAT_SPEED_RST;
      end
    end else if (cfg_we) begin
      if (cfg_addr == REG_FILTER_TIME) begin
        filter_time_r <= cfg_wdata[FT_W-1:0];
      end
      for (int k = 0; k < KEYS_MAX; k++) begin
        if (cfg_addr == LONG_IDX[k]) begin
          long_time_r[k] <= cfg_wdata;
        end
        if (cfg_addr == REPEAT_IDX[k]) begin
          repeat_speed_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // One lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    assign key_clr[k] = cfg_we && (cfg_addr == LONG_IDX[k] || cfg_addr == REPEAT_IDX[k]);

    kd_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .tick         (in_accept),
      .level        (in_tdata[k]),
      .clr          (key_clr[k]),
      .filter_time  (filter_time_r),
      .long_time    (long_time_r[k]),
      .repeat_speed (repeat_speed_r[k]),
      .ev           (lane_ev[k])
    );
  end

  // Serialize the events of a tick
  kd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .ev        (lane_ev),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_code  (out_code),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

  assign out_tdata = {{(8 - CODE_W){1'b0}}, out_code};

`ifndef NO_ASSERTIONS
  // A stalled word that is not the last of its tick keeps the input closed
  a_busy_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast && !out_tready) |-> !in_tready)
    else $error("input open while events of a tick are pending");

  // Output only starts after a taken tick has passed through the pending mask and the output register
  a_out_follows_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("output word without a preceding tick");
`endif

endmodule

>>> design/kd_lane.sv
// One key lane: hysteresis filter, held flag, long press and repeat counters.
module kd_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tick,
  input  logic                      level,
  input  logic                      clr,
  input  logic [kd_pkg::FT_W-1:0]   filter_time,
  input  logic [kd_pkg::CNT_W-1:0]  long_time,
  input  logic [kd_pkg::CNT_W-1:0]  repeat_speed,
  output kd_pkg::lane_ev_t          ev
);
  import kd_pkg::*;

  logic [FC_W-1:0]  fc_r, fc_nxt;
  logic             held_r, held_nxt;
  logic [CNT_W-1:0] lc_r, lc_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt;
  logic [FC_W-1:0]  ft1;
  logic [FC_W-1:0]  ft2;
  logic [CNT_W:0]   lc_inc;
  logic [CNT_W:0]   rc_inc;

  // Work out the next key state and the events of this tick
  always_comb begin
    ft1      = {1'b0, filter_time};
    ft2      = {filter_time, 1'b0};
    lc_inc   = {1'b0, lc_r} + 17'd1;
    rc_inc   = {1'b0, rc_r} + 17'd1;
    fc_nxt   = fc_r;
    held_nxt = held_r;
    lc_nxt   = lc_r;
    rc_nxt   = rc_r;
    ev       = '0;
    if (!level) begin
      if (fc_r < ft1) begin
        fc_nxt = ft1;
      end else if (fc_r < ft2) begin
        fc_nxt = fc_r + 8'd1;
      end else begin
        if (!held_r) begin
          held_nxt     = 1'b1;
          ev.first_vld = 1'b1;
        end
        if (long_time != '0) begin
          if (lc_r < long_time) begin
            lc_nxt = lc_inc[CNT_W-1:0];
            if (lc_inc[CNT_W-1:0] == long_time) begin
              ev.second_vld  = 1'b1;
              ev.second_long = 1'b1;
            end
          end else if (repeat_speed != '0) begin
            if (rc_inc >= {1'b0, repeat_speed}) begin
              rc_nxt        = '0;
              ev.second_vld = 1'b1;
            end else begin
              rc_nxt = rc_inc[CNT_W-1:0];
            end
          end
        end
      end
    end else begin
      if (fc_r > ft1) begin
        fc_nxt = ft1;
      end else if (fc_r != '0) begin
        fc_nxt = fc_r - 8'd1;
      end else if (held_r) begin
        held_nxt     = 1'b0;
        ev.first_vld = 1'b1;
        ev.first_rel = 1'b1;
      end
      lc_nxt = '0;
      rc_nxt = '0;
    end
  end

  // Advance key state on an accepted tick; a config write clears counters instead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r   <= FILTER_COUNT_RST;
      held_r <= 1'b0;
      lc_r   <= '0;
      rc_r   <= '0;
    end else if (clr) begin
      lc_r <= '0;
      rc_r <= '0;
    end else if (tick) begin
      fc_r   <= fc_nxt;
      held_r <= held_nxt;
      lc_r   <= lc_nxt;
      rc_r   <= rc_nxt;
    end
  end

endmodule

>>> design/kd_merge.sv
// Merge stage: latch the lanes' events and send them out one word a cycle while out_ready allows, in key order.
module kd_merge #(
  parameter int NUM_KEYS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  kd_pkg::lane_ev_t [NUM_KEYS-1:0]     ev,
  output logic                                ready,
  output logic                                out_valid,
  output kd_pkg::code_t                       out_code,
  output logic                                out_last,
  input  logic                                out_ready
);
  import kd_pkg::*;

  localparam int SLOTS = 2 * NUM_KEYS;

  logic [SLOTS-1:0] mask_r, mask_nxt;
  logic [SLOTS-1:0] kind_r;
  logic [SLOTS-1:0] mask_new;
  logic [SLOTS-1:0] kind_new;
  logic [SLOTS-1:0] pick_oh;
  logic [SLOTS-1:0] mask_left;
  logic [SLOTS-1:0] mask_after;
  code_t            slot_code [SLOTS];
  code_t            pick_code;
  code_t            code_r;
  logic             last_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;

  // Lay the lanes' events out as two slots per key
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      mask_new[2*k]   = ev[k].first_vld;
      kind_new[2*k]   = ev[k].first_rel;
      mask_new[2*k+1] = ev[k].second_vld;
      kind_new[2*k+1] = ev[k].second_long;
    end
  end

  // Code of each slot: even slots press or release, odd slots repeat or long
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if ((i & 1) == 0) begin
        slot_code[i] = CODE_W'(3 * (i >> 1)) + (kind_r[i] ? CODE_RELEASE : CODE_PRESS);
      end else begin
        slot_code[i] = CODE_W'(3 * (i >> 1)) + (kind_r[i] ? CODE_LONG : CODE_PRESS);
      end
    end
  end

  // Pick the lowest pending slot
  always_comb begin
    pick_oh   = '0;
    pick_code = slot_code[0];
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick_oh    = '0;
        pick_oh[i] = 1'b1;
        pick_code  = slot_code[i];
      end
    end
  end

  // Move one word into the output register whenever it is free or drained
  always_comb begin
    out_load      = (mask_r != '0) && (!out_valid_r || out_ready);
    mask_left     = mask_r & ~pick_oh;
    mask_after    = out_load ? mask_left : mask_r;
    ready         = (mask_after == '0);
    mask_nxt      = load ? mask_new : mask_after;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold event kinds and the output word
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_new;
    end
    if (out_load) begin
      code_r <= pick_code;
      last_r <= (mask_left == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = code_r;
  assign out_last  = last_r;

endmodule
